### design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### design/pmd_pkg.sv
// Package with the shared types and constants of the mip downsampler.
`timescale 1ns / 1ps
package pmd_pkg;
    localparam int MAX_DIM_DEF = 2048;
    localparam int CFG_W = 12;
    localparam logic [0:0] REG_WIDTH = 1'd0;
    localparam logic [0:0] REG_HEIGHT = 1'd1;
    localparam int QDEPTH = 4;

    // Footprint job handed from the front part to the back part.
    typedef struct packed {
        logic [31:0] tl;
        logic [31:0] tr;
        logic [31:0] bl;
        logic [31:0] br;
        logic        last;
    } job_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } texel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       level_done;
    } result_t;
endpackage

### design/pmd_stream_if.sv
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface pmd_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/pmd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### design/pmd_front.sv
// Front part: counts texels, keeps the even row and assembles footprints.
`timescale 1ns / 1ps
module pmd_front
    import pmd_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_sel,
    input  logic             cfg_hit,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  texel_t           in_texel,
    output logic             job_valid,
    input  logic             job_ready,
    output job_t             job
);
    localparam int AW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    // Three phases: take a texel; wait for the store read; hand over the job.
    localparam logic [1:0] ST_TAKE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [DW-1:0]    w_eff, h_eff, dw, dh;
    logic [DW-1:0]    col_reg, row_reg;
    logic [1:0]       state_reg;
    logic [31:0]      left_reg, cur_reg, tl_reg;
    logic             last_reg, hone_reg, wone_reg;
    logic [AW-1:0]    ridx_reg;
    logic [31:0]      rdata;
    logic [31:0]      cur;
    logic             col_end, row_end, take, st_we, rd_en;
    logic [DW-1:0]    cc, rr, x, y;
    logic [AW-1:0]    li;

    function automatic logic [DW-1:0] eff(input logic [CFG_W-1:0] v);
        logic [CFG_W:0] vx;
        vx = {1'b0, v};
        if (v == '0)
            return DW'(1);
        else if (32'(vx) > MAX_DIM)
            return DW'(MAX_DIM);
        else
            return DW'(vx);
    endfunction

    assign w_eff = eff(width_reg);
    assign h_eff = eff(height_reg);
    assign dw = (w_eff > DW'(1)) ? (w_eff >> 1) : DW'(1);
    assign dh = (h_eff > DW'(1)) ? (h_eff >> 1) : DW'(1);
    assign cc = (col_reg >= w_eff) ? '0 : col_reg;
    assign rr = (row_reg >= h_eff) ? '0 : row_reg;
    assign cur = in_texel;
    assign in_ready = (state_reg == ST_TAKE);
    assign take = in_valid && in_ready;
    assign col_end = (w_eff == DW'(1)) ? (cc == '0) : (cc[0] && ((cc >> 1) < dw));
    assign row_end = (h_eff == DW'(1)) ? (rr == '0) : (rr[0] && ((rr >> 1) < dh));
    assign x = (w_eff == DW'(1)) ? '0 : (cc >> 1);
    assign y = (h_eff == DW'(1)) ? '0 : (rr >> 1);
    assign li = (w_eff == DW'(1)) ? '0 : AW'(cc - DW'(1));
    assign st_we = take && (h_eff > DW'(1)) && !rr[0];
    // The first store read happens in the take cycle, the second one after.
    assign rd_en = (take && col_end && row_end) || (state_reg == ST_READ);

    pmd_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (AW'(cc)),
        .wdata (cur),
        .re    (rd_en),
        .raddr ((state_reg == ST_READ) ? ridx_reg : li),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= CFG_W'(1);
            height_reg <= CFG_W'(1);
            col_reg <= '0;
            row_reg <= '0;
            left_reg <= '0;
            state_reg <= ST_TAKE;
        end
        else
        begin
            if (cfg_we && cfg_hit)
            begin
                if (cfg_sel == REG_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (take)
            begin
                if (!cc[0])
                    left_reg <= cur;
                if (cc + DW'(1) >= w_eff)
                begin
                    col_reg <= '0;
                    row_reg <= (rr + DW'(1) >= h_eff) ? '0 : rr + DW'(1);
                end
                else
                begin
                    col_reg <= cc + DW'(1);
                    row_reg <= rr;
                end
            end
            unique case (state_reg)
                ST_TAKE:
                begin
                    if (take && col_end && row_end)
                        state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (job_ready)
                        state_reg <= ST_TAKE;
                end
                default:
                begin
                    state_reg <= ST_TAKE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= cur;
            ridx_reg <= AW'(cc);
            last_reg <= (x == dw - DW'(1)) && (y == dh - DW'(1));
            hone_reg <= (h_eff == DW'(1));
            wone_reg <= !cc[0];
        end
        if (state_reg == ST_READ)
            tl_reg <= rdata;
    end

    logic [31:0] left_now;
    // The left texel of a width-1 footprint is the current texel itself.
    assign left_now = wone_reg ? cur_reg : left_reg;
    assign job_valid = (state_reg == ST_EMIT);
    assign job.tl = hone_reg ? left_now : tl_reg;
    assign job.tr = hone_reg ? cur_reg : rdata;
    assign job.bl = left_now;
    assign job.br = cur_reg;
    assign job.last = last_reg;

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_read_then_emit, clk, rst_n, state_reg == ST_READ,
        state_reg == ST_EMIT, "store read not followed by emit")
    `ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_reg != ST_TAKE, !in_ready,
        "texel accepted while a footprint is pending")
    `ASSERT_NEXT(a_hold_emit, clk, rst_n, job_valid && !job_ready, job_valid,
        "job dropped while stalled")
endmodule

### design/pmd_queue.sv
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
module pmd_queue
    import pmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);
    localparam int PW = $clog2(QDEPTH);
    job_t          slot_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_job = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + PW'(1);
            if (pop)
                rp_reg <= rp_reg + PW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (PW+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= in_job;
    end
endmodule

### design/pmd_back.sv
// Back part: weighted sums and a shared serial divider for the three colours.
`timescale 1ns / 1ps
module pmd_back
    import pmd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  state_reg;
    job_t        job_reg;
    logic [9:0]  asum_reg;
    logic [17:0] csum_reg [3];
    logic [1:0]  ch_reg;
    logic [4:0]  bit_reg;
    logic [18:0] num_reg;
    logic [10:0] rem_reg;
    logic [7:0]  col_reg [3];
    texel_t      t0, t1, t2, t3;
    logic [10:0] trial;

    assign t0 = job_reg.tl;
    assign t1 = job_reg.tr;
    assign t2 = job_reg.bl;
    assign t3 = job_reg.br;
    assign job_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign trial = {rem_reg[9:0], num_reg[18]};

    function automatic logic [17:0] wsum(input logic [7:0] c0, c1, c2, c3,
                                         input texel_t a0, a1, a2, a3);
        return 18'(16'(c0) * 16'(a0.alpha)) + 18'(16'(c1) * 16'(a1.alpha))
             + 18'(16'(c2) * 16'(a2.alpha)) + 18'(16'(c3) * 16'(a3.alpha));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
        begin
            unique case (state_reg)
                ST_IDLE: if (job_valid) state_reg <= ST_SUM;
                ST_SUM: state_reg <= (asum_reg == '0) ? ST_OUT : ST_DIV;
                ST_DIV:
                    if (bit_reg == 5'd18 && ch_reg == 2'd2)
                        state_reg <= ST_OUT;
                ST_OUT: if (res_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                job_reg <= job;
                asum_reg <= 10'(job.tl[7:0]) + 10'(job.tr[7:0])
                          + 10'(job.bl[7:0]) + 10'(job.br[7:0]);
            end
            ST_SUM:
            begin
                csum_reg[0] <= wsum(t0.red, t1.red, t2.red, t3.red, t0, t1, t2, t3);
                csum_reg[1] <= wsum(t0.green, t1.green, t2.green, t3.green,
                                    t0, t1, t2, t3);
                csum_reg[2] <= wsum(t0.blue, t1.blue, t2.blue, t3.blue,
                                    t0, t1, t2, t3);
                ch_reg <= 2'd0;
                bit_reg <= 5'd0;
                rem_reg <= '0;
                num_reg <= 19'(wsum(t0.red, t1.red, t2.red, t3.red, t0, t1, t2, t3))
                         + 19'(asum_reg >> 1);
                col_reg[0] <= '0;
                col_reg[1] <= '0;
                col_reg[2] <= '0;
            end
            ST_DIV:
            begin
                // Restoring division, one quotient bit a cycle.
                if (bit_reg == 5'd18)
                begin
                    col_reg[ch_reg] <= {num_reg[6:0], (trial >= {1'b0, asum_reg})};
                    bit_reg <= '0;
                    rem_reg <= '0;
                    if (ch_reg != 2'd2)
                    begin
                        ch_reg <= ch_reg + 2'd1;
                        num_reg <= 19'(csum_reg[ch_reg + 2'd1]) + 19'(asum_reg >> 1);
                    end
                end
                else
                begin
                    if (trial >= {1'b0, asum_reg})
                        rem_reg <= trial - {1'b0, asum_reg};
                    else
                        rem_reg <= trial;
                    num_reg <= {num_reg[17:0], (trial >= {1'b0, asum_reg})};
                    bit_reg <= bit_reg + 5'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    logic [9:0] around;
    assign around = asum_reg + 10'd2;
    assign res.red = col_reg[0];
    assign res.green = col_reg[1];
    assign res.blue = col_reg[2];
    assign res.alpha = around[9:2];
    assign res.level_done = job_reg.last;

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_hold_out, clk, rst_n, res_valid && !res_ready, res_valid,
        "result dropped while stalled")
    `ASSERT_IMPL(a_busy, clk, rst_n, state_reg != ST_IDLE, !job_ready,
        "job taken while busy")
endmodule

### design/premultiplied_mip_downsample.sv
// Top level of the premultiplied-alpha 2x2 mip downsampler.
// Throughput: one texel a cycle while no footprint is pending; a texel that
// completes a footprint holds the input through the row-store read and the job
// hand-over. The shared serial divider finishes one result before the next job.
// A four-entry job queue decouples the front from the divider.
// Reset: asynchronous, active low; sizes 1x1, counters at the first texel.
`timescale 1ns / 1ps
module premultiplied_mip_downsample
    import pmd_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    pmd_stream_if.sink       texel_in,
    pmd_stream_if.source     result
);
    logic    fj_valid, fj_ready, qj_valid, qj_ready;
    job_t    fjob, qjob;
    result_t r;

    pmd_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk (clk), .rst_n (rst_n),
        .cfg_we (cfg_we), .cfg_sel (cfg_index), .cfg_hit (1'b1),
        .cfg_data (cfg_data),
        .in_valid (texel_in.valid), .in_ready (texel_in.ready),
        .in_texel (texel_in.data),
        .job_valid (fj_valid), .job_ready (fj_ready), .job (fjob)
    );

    pmd_queue u_queue (
        .clk (clk), .rst_n (rst_n),
        .in_valid (fj_valid), .in_ready (fj_ready), .in_job (fjob),
        .out_valid (qj_valid), .out_ready (qj_ready), .out_job (qjob)
    );

    pmd_back u_back (
        .clk (clk), .rst_n (rst_n),
        .job_valid (qj_valid), .job_ready (qj_ready), .job (qjob),
        .res_valid (result.valid), .res_ready (result.ready), .res (r)
    );

    assign result.data = r;
endmodule
